### src/assert_macros.svh
// Assertion macros shared by the battery charge supervisor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define BCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is held.
`define BCS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### src/bcs_pkg.sv
// Shared types, constants and the current level table of the battery charge supervisor.
`default_nettype none

package bcs_pkg;

    localparam int CURRENT_LEVELS = 16;
    localparam int ADC_BITS       = 10;

    localparam int MV_W    = 13;
    localparam int MA_W    = 11;
    localparam int ISEN_W  = 15;
    localparam int LEVEL_W = 4;
    localparam int START_W = 4;
    localparam int WAIT_W  = 6;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 3;

    localparam int FULL_MV     = 5600;
    localparam int ADC_FULL    = (1 << ADC_BITS) - 1;
    localparam int LEVEL_COUNT = (CURRENT_LEVELS < 16) ? CURRENT_LEVELS : 16;

    localparam logic [MA_W-1:0]    RST_MAX_CURRENT  = MA_W'(450);
    localparam logic [MA_W-1:0]    RST_MIN_CURRENT  = MA_W'(50);
    localparam logic [MV_W-1:0]    RST_RECHARGE_MV  = MV_W'(3800);
    localparam logic [START_W-1:0] RST_START_TICKS  = START_W'(3 * 2);
    localparam logic [WAIT_W-1:0]  RST_WAIT_TICKS   = WAIT_W'(10 * 2);

    localparam logic [MA_W-1:0] LEVEL_LIMIT [16] = '{
        MA_W'(70),   MA_W'(200),  MA_W'(300),  MA_W'(450),
        MA_W'(550),  MA_W'(650),  MA_W'(700),  MA_W'(800),
        MA_W'(900),  MA_W'(1000), MA_W'(1100), MA_W'(1200),
        MA_W'(1300), MA_W'(1400), MA_W'(1500), MA_W'(1600)
    };

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_DETECT = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_STARTED  = 2'd1,
        EV_COMPLETE = 2'd2,
        EV_RESTART  = 2'd3
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_CURRENT  = 3'd0,
        CFG_MIN_CURRENT  = 3'd1,
        CFG_RECHARGE_MV  = 3'd2,
        CFG_START_TICKS  = 3'd3,
        CFG_WAIT_TICKS   = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] level;
    } t_level;

    // Highest table entry whose limit is not above the maximum current.
    function automatic t_level level_of(input logic [MA_W-1:0] max_ma);
        t_level res;
        res.valid = 1'b0;
        res.level = '0;
        for (int i = 0; i < LEVEL_COUNT; i++) begin
            if (max_ma >= LEVEL_LIMIT[i]) begin
                res.valid = 1'b1;
                res.level = LEVEL_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### src/bcs_scale.sv
// ADC code to millivolt conversion: full-scale product divided by the full-scale code.
`default_nettype none

module bcs_scale (
    input  wire logic [bcs_pkg::ADC_BITS-1:0] i_code,
    output logic      [bcs_pkg::MV_W-1:0]     o_mv
);
    import bcs_pkg::*;

    localparam int PROD_W = MV_W + ADC_BITS;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - ADC_BITS;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  approx;
    logic [Q_W-1:0]    q_est;
    logic [SUM_W-1:0]  q_back;
    logic [SUM_W-1:0]  rem;

    // Divide by 2^N - 1 as a multiply by 2^N/(2^N - 1): the series estimate
    // is at most one low, so one compare and step fixes it.
    assign prod   = PROD_W'(i_code) * PROD_W'(FULL_MV);
    assign approx = SUM_W'(prod) + SUM_W'(prod >> ADC_BITS) + SUM_W'(prod >> (2 * ADC_BITS));
    assign q_est  = approx[SUM_W-1:ADC_BITS];
    assign q_back = (SUM_W'(q_est) << ADC_BITS) - SUM_W'(q_est);
    assign rem    = SUM_W'(prod) - q_back;

    always_comb begin
        if (rem >= SUM_W'(ADC_FULL)) begin
            o_mv = MV_W'(q_est + Q_W'(1));
        end else begin
            o_mv = MV_W'(q_est);
        end
    end

endmodule

`default_nettype wire

### src/battery_charge_supervisor.sv
// Top level of the battery charge supervisor: item pipeline, charge state and result register.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------------
//   in      | input     | i_in_valid / o_in_stall   | opcode, charger_present, cv_detected, codes
//   out     | output    | o_out_valid / i_out_stall | charger_on ... event_res
//   cfg     | input     | i_cfg_we (no handshake)   | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output does not stall; an accepted item
// passes through the input register, the conversion register and the result
// register before its result shows on the output.
// The charge state is updated in the last stage only.
// Synchronous active-low reset clears the pipeline, the charge state and
// restores the register defaults. A stall on the output backs up stage by stage
// and reaches o_in_stall only once every stage holds an item.
`default_nettype none

module battery_charge_supervisor (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_cfg_we,
    input  wire logic [bcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bcs_pkg::CFG_W-1:0]      i_cfg_data,

    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_opcode,
    input  wire logic                           i_charger_present,
    input  wire logic                           i_cv_detected,
    input  wire logic [bcs_pkg::ADC_BITS-1:0]   i_vbat_code,
    input  wire logic [bcs_pkg::ADC_BITS-1:0]   i_isense_code,

    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_charger_on,
    output logic                                o_cc_mode,
    output logic [bcs_pkg::LEVEL_W-1:0]         o_current_level,
    output logic                                o_level_valid,
    output logic [bcs_pkg::MV_W-1:0]            o_vbat_mv,
    output logic [bcs_pkg::ISEN_W-1:0]          o_isense_ma,
    output logic                                o_charging,
    output logic [1:0]                          o_event_res
);
    import bcs_pkg::*;

    `include "assert_macros.svh"

    // Configuration registers.
    logic [MA_W-1:0]    r_max_current;
    logic [MA_W-1:0]    r_min_current;
    logic [MV_W-1:0]    r_recharge_mv;
    logic [START_W-1:0] r_start_ticks;
    logic [WAIT_W-1:0]  r_wait_ticks;

    // Stage 1: raw item.
    logic                r_s1_valid;
    t_opcode             r_s1_op;
    logic                r_s1_present;
    logic                r_s1_cv;
    logic [ADC_BITS-1:0] r_s1_vbat_code;
    logic [ADC_BITS-1:0] r_s1_isense_code;

    // Stage 2: item with both voltages in millivolts.
    logic                r_s2_valid;
    t_opcode             r_s2_op;
    logic                r_s2_present;
    logic                r_s2_cv;
    logic [MV_W-1:0]     r_s2_vbat_mv;
    logic [MV_W-1:0]     r_s2_sense_mv;

    // Stage 3: result register.
    logic                r_s3_valid;
    logic                r_o_charger_on;
    logic                r_o_cc_mode;
    t_level              r_o_level;
    logic [MV_W-1:0]     r_o_vbat_mv;
    logic [ISEN_W-1:0]   r_o_isense_ma;
    logic                r_o_charging;
    t_event              r_o_event;

    // Charge state.
    logic                r_prev_present, n_prev_present;
    logic                r_charging,     n_charging;
    logic [START_W-1:0]  r_start_count,  n_start_count;
    logic [WAIT_W-1:0]   r_recharge_count, n_recharge_count;
    logic                r_charger_en,   n_charger_en;
    logic                r_cc_en,        n_cc_en;

    logic                n_vbat_zero_on_detect;
    logic [MV_W-1:0]     n_vbat_mv;
    logic [ISEN_W-1:0]   n_isense_ma;
    t_event              n_event;
    t_level              level_now;

    logic [MV_W-1:0]     s1_vbat_mv;
    logic [MV_W-1:0]     s1_sense_mv;

    logic                ready1, ready2, ready3;
    logic                take_in, adv12, adv23;

    // ---------------------------------------------------------------------
    // Handshake: each stage moves when the stage after it is free or moving.
    // ---------------------------------------------------------------------
    assign ready3  = !r_s3_valid || !i_out_stall;
    assign ready2  = !r_s2_valid || ready3;
    assign ready1  = !r_s1_valid || ready2;
    assign take_in = i_in_valid && ready1;
    assign adv12   = r_s1_valid && ready2;
    assign adv23   = r_s2_valid && ready3;

    assign o_in_stall = !ready1;

    // ---------------------------------------------------------------------
    // Configuration writes; indexes beyond the list are dropped.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_current <= RST_MAX_CURRENT;
            r_min_current <= RST_MIN_CURRENT;
            r_recharge_mv <= RST_RECHARGE_MV;
            r_start_ticks <= RST_START_TICKS;
            r_wait_ticks  <= RST_WAIT_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_CURRENT: begin
                    r_max_current <= i_cfg_data[MA_W-1:0];
                end
                CFG_MIN_CURRENT: begin
                    r_min_current <= i_cfg_data[MA_W-1:0];
                end
                CFG_RECHARGE_MV: begin
                    r_recharge_mv <= i_cfg_data[MV_W-1:0];
                end
                CFG_START_TICKS: begin
                    r_start_ticks <= i_cfg_data[START_W-1:0];
                end
                CFG_WAIT_TICKS: begin
                    r_wait_ticks <= i_cfg_data[WAIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: capture the item as it arrives.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (ready1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_s1_op          <= t_opcode'(i_opcode);
            r_s1_present     <= i_charger_present;
            r_s1_cv          <= i_cv_detected;
            r_s1_vbat_code   <= i_vbat_code;
            r_s1_isense_code <= i_isense_code;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: scale both codes to millivolts.
    // ---------------------------------------------------------------------
    bcs_scale u_scale_vbat (
        .i_code (r_s1_vbat_code),
        .o_mv   (s1_vbat_mv)
    );

    bcs_scale u_scale_sense (
        .i_code (r_s1_isense_code),
        .o_mv   (s1_sense_mv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (ready2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv12) begin
            r_s2_op       <= r_s1_op;
            r_s2_present  <= r_s1_present;
            r_s2_cv       <= r_s1_cv;
            r_s2_vbat_mv  <= s1_vbat_mv;
            r_s2_sense_mv <= s1_sense_mv;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: charge state update for the item leaving stage 2.
    // ---------------------------------------------------------------------
    always_comb begin
        logic [MV_W-1:0] diff;
        logic            reached;

        n_prev_present   = r_prev_present;
        n_charging       = r_charging;
        n_start_count    = r_start_count;
        n_recharge_count = r_recharge_count;
        n_charger_en     = r_charger_en;
        n_cc_en          = r_cc_en;
        n_event          = EV_NONE;
        level_now        = level_of(r_max_current);

        // Voltage difference only counts when sense is above the battery.
        if (r_s2_sense_mv >= r_s2_vbat_mv) begin
            diff = r_s2_sense_mv - r_s2_vbat_mv;
        end else begin
            diff = '0;
        end

        n_vbat_zero_on_detect = (r_s2_op == OP_DETECT);
        n_vbat_mv   = n_vbat_zero_on_detect ? '0 : r_s2_vbat_mv;
        n_isense_ma = n_vbat_zero_on_detect ? '0 :
                      (ISEN_W'(diff) << 2) + ISEN_W'(diff);
        reached     = 1'b0;

        if (r_s2_op == OP_DETECT) begin
            // Detect interrupt: drop the debounce and the charging flag.
            n_start_count = '0;
            n_charging    = 1'b0;
        end else begin
            // Follow charger insertion and removal.
            if (r_prev_present != r_s2_present) begin
                n_prev_present = r_s2_present;
                n_charger_en   = r_s2_present && level_now.valid;
                n_cc_en        = r_s2_present && level_now.valid;
            end

            if (r_s2_present) begin
                if (r_s2_cv && n_cc_en) begin
                    n_cc_en = 1'b0;
                end
                if (n_isense_ma != '0) begin
                    if (n_isense_ma <= ISEN_W'(r_min_current)) begin
                        // Current down to the minimum: charge complete.
                        n_start_count = '0;
                        n_charger_en  = 1'b0;
                        n_cc_en       = 1'b0;
                        if (r_charging) begin
                            n_event = EV_COMPLETE;
                        end
                    end else if (n_start_count < r_start_ticks) begin
                        n_start_count = n_start_count + START_W'(1);
                    end
                end else begin
                    if (n_start_count != '0) begin
                        n_start_count = n_start_count - START_W'(1);
                    end
                    if (r_s2_vbat_mv < r_recharge_mv) begin
                        if (n_recharge_count != '0) begin
                            n_recharge_count = n_recharge_count - WAIT_W'(1);
                        end else begin
                            // Timeout below the recharge voltage: restart.
                            n_charger_en     = level_now.valid;
                            n_cc_en          = level_now.valid;
                            n_recharge_count = r_wait_ticks;
                            n_event          = EV_RESTART;
                        end
                    end else begin
                        n_recharge_count = '0;
                    end
                end
            end else begin
                n_start_count    = '0;
                n_recharge_count = '0;
            end

            // Debounce settles the charging flag; a start wins over a restart.
            reached = (n_start_count == r_start_ticks);
            if (r_charging != reached) begin
                if (!r_charging && reached) begin
                    n_charging = 1'b1;
                    n_event    = EV_STARTED;
                end else if (n_start_count == '0) begin
                    n_charging = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid       <= 1'b0;
            r_prev_present   <= 1'b0;
            r_charging       <= 1'b0;
            r_start_count    <= '0;
            r_recharge_count <= '0;
            r_charger_en     <= 1'b0;
            r_cc_en          <= 1'b0;
        end else begin
            if (ready3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (adv23) begin
                r_prev_present   <= n_prev_present;
                r_charging       <= n_charging;
                r_start_count    <= n_start_count;
                r_recharge_count <= n_recharge_count;
                r_charger_en     <= n_charger_en;
                r_cc_en          <= n_cc_en;
            end
        end
    end

    // Result payload: hold while the output is stalled.
    always_ff @(posedge i_clk) begin
        if (adv23) begin
            r_o_charger_on <= n_charger_en;
            r_o_cc_mode    <= n_cc_en;
            r_o_level      <= level_now;
            r_o_vbat_mv    <= n_vbat_mv;
            r_o_isense_ma  <= n_isense_ma;
            r_o_charging   <= n_charging;
            r_o_event      <= n_event;
        end
    end

    assign o_out_valid     = r_s3_valid;
    assign o_charger_on    = r_o_charger_on;
    assign o_cc_mode       = r_o_cc_mode;
    assign o_current_level = r_o_level.level;
    assign o_level_valid   = r_o_level.valid;
    assign o_vbat_mv       = r_o_vbat_mv;
    assign o_isense_ma     = r_o_isense_ma;
    assign o_charging      = r_o_charging;
    assign o_event_res     = r_o_event;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    `BCS_ASSERT(a_cc_needs_charger, !r_cc_en || r_charger_en, "cc mode on with charger off")
    `BCS_ASSERT(a_complete_turns_off, (o_out_valid && r_o_event == EV_COMPLETE) |-> !o_charger_on, "charge complete left the charger on")
    `BCS_ASSERT(a_started_sets_flag, (o_out_valid && r_o_event == EV_STARTED) |-> o_charging, "start event without charging flag")
    `BCS_ASSERT(a_restart_follows_level, (o_out_valid && r_o_event == EV_RESTART) |-> (o_charger_on == o_level_valid), "restart charger state does not follow level")

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the battery charge supervisor, with its own charge predictor.

module tb_top;
    import bcs_pkg::*;

    // Current limit table, lowest first; index is the reported current level.
    localparam int unsigned LEVEL_MA [16] = '{
        70, 200, 300, 450, 550, 650, 700, 800,
        900, 1000, 1100, 1200, 1300, 1400, 1500, 1600
    };
    localparam int unsigned CODE_FULL   = (1 << ADC_BITS) - 1;
    localparam int          PHASE_ITEMS = 235;
    localparam int          PHASES      = 8;

    typedef struct packed {
        t_opcode               op;
        logic                  present;
        logic                  cv;
        logic [ADC_BITS-1:0]   vbat;
        logic [ADC_BITS-1:0]   isense;
    } t_sense_item;

    typedef struct packed {
        logic                  charger_on;
        logic                  cc_mode;
        logic [LEVEL_W-1:0]    level;
        logic                  level_valid;
        logic [MV_W-1:0]       vbat_mv;
        logic [ISEN_W-1:0]     isense_ma;
        logic                  charging;
        t_event                ev;
    } t_charge_result;

    // Kinds of stretch in the random stimulus: steady charging, current tapering off
    // towards the minimum, resting with no current, and unstructured noise.
    typedef enum int {
        SEG_CHARGE,
        SEG_TAPER,
        SEG_REST,
        SEG_NOISE
    } t_segment;

    // Predicts the charge state per accepted item and checks the results against it.
    class charge_checker;
        logic [MA_W-1:0]    max_ma;
        logic [MA_W-1:0]    min_ma;
        logic [MV_W-1:0]    recharge_mv;
        logic [START_W-1:0] start_ticks;
        logic [WAIT_W-1:0]  restart_wait;

        logic               prev_present;
        logic               charging_flag;
        logic               charger_en;
        logic               cc_en;
        logic [START_W-1:0] start_cnt;
        logic [WAIT_W-1:0]  recharge_cnt;

        t_charge_result     pending_results [$];
        int unsigned        n_items, n_detect, n_started, n_complete, n_restart;
        int unsigned        n_checked, mismatches;

        function new();
            max_ma        = RST_MAX_CURRENT;
            min_ma        = RST_MIN_CURRENT;
            recharge_mv   = RST_RECHARGE_MV;
            start_ticks   = RST_START_TICKS;
            restart_wait  = RST_WAIT_TICKS;
            prev_present  = 1'b0;
            charging_flag = 1'b0;
            charger_en    = 1'b0;
            cc_en         = 1'b0;
            start_cnt     = '0;
            recharge_cnt  = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_MAX_CURRENT: max_ma       = data[MA_W-1:0];
                CFG_MIN_CURRENT: min_ma       = data[MA_W-1:0];
                CFG_RECHARGE_MV: recharge_mv  = data[MV_W-1:0];
                CFG_START_TICKS: start_ticks  = data[START_W-1:0];
                CFG_WAIT_TICKS:  restart_wait = data[WAIT_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned code_to_mv(logic [ADC_BITS-1:0] code);
            int unsigned c;
            c = code;
            if (c > CODE_FULL) c = CODE_FULL;
            return (FULL_MV * c) / CODE_FULL;
        endfunction

        // The charger only comes on with a usable current level and a charger present.
        function void request_charger(logic want, logic present);
            if (want && present && (max_ma >= LEVEL_MA[0])) begin
                charger_en = 1'b1;
                cc_en      = 1'b1;
            end else begin
                charger_en = 1'b0;
                cc_en      = 1'b0;
            end
        endfunction

        function void take_item(t_sense_item it);
            t_charge_result r;
            int unsigned    vb, se, isen;
            logic           reached;
            t_event         ev;

            vb   = 0;
            isen = 0;
            ev   = EV_NONE;
            n_items++;
            if (it.op == OP_DETECT) begin
                n_detect++;
                start_cnt     = '0;
                charging_flag = 1'b0;
            end else begin
                if (prev_present != it.present) begin
                    prev_present = it.present;
                    request_charger(it.present, it.present);
                end
                vb   = code_to_mv(it.vbat);
                se   = code_to_mv(it.isense);
                isen = (se >= vb) ? 5 * (se - vb) : 0;

                if (it.present) begin
                    if (it.cv && cc_en) cc_en = 1'b0;
                    if (isen != 0) begin
                        if (isen <= min_ma) begin
                            start_cnt = '0;
                            request_charger(1'b0, it.present);
                            if (charging_flag) ev = EV_COMPLETE;
                        end else if (start_cnt < start_ticks) begin
                            start_cnt = start_cnt + 1'b1;
                        end
                    end else begin
                        if (start_cnt != 0) start_cnt = start_cnt - 1'b1;
                        if (vb < recharge_mv) begin
                            if (recharge_cnt != 0) begin
                                recharge_cnt = recharge_cnt - 1'b1;
                            end else begin
                                request_charger(1'b1, it.present);
                                recharge_cnt = restart_wait;
                                ev = EV_RESTART;
                            end
                        end else begin
                            recharge_cnt = '0;
                        end
                    end
                end else begin
                    start_cnt    = '0;
                    recharge_cnt = '0;
                end

                // Started wins over a restart in the same tick; the flag drops only at zero.
                reached = (start_cnt == start_ticks);
                if (charging_flag != reached) begin
                    if (!charging_flag) begin
                        charging_flag = 1'b1;
                        ev = EV_STARTED;
                    end else if (start_cnt == 0) begin
                        charging_flag = 1'b0;
                    end
                end
            end

            case (ev)
                EV_STARTED:  n_started++;
                EV_COMPLETE: n_complete++;
                EV_RESTART:  n_restart++;
                default: ;
            endcase

            r.level       = '0;
            r.level_valid = 1'b0;
            for (int i = 0; i < 16; i++) begin
                if (max_ma >= LEVEL_MA[i]) begin
                    r.level       = LEVEL_W'(i);
                    r.level_valid = 1'b1;
                end
            end
            r.charger_on = charger_en;
            r.cc_mode    = cc_en;
            r.vbat_mv    = MV_W'(vb);
            r.isense_ma  = ISEN_W'(isen);
            r.charging   = charging_flag;
            r.ev         = ev;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
            if (want !== seen) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: %s expected %0d, got %0d", n_checked, name, want, seen);
            end
        endfunction

        function void check_result(t_charge_result got);
            t_charge_result want;
            n_checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: arrived with no item waiting for it", n_checked);
                return;
            end
            want = pending_results.pop_front();
            compare_field("charger_on",    want.charger_on,  got.charger_on);
            compare_field("cc_mode",       want.cc_mode,     got.cc_mode);
            compare_field("current_level", want.level,       got.level);
            compare_field("level_valid",   want.level_valid, got.level_valid);
            compare_field("vbat_mv",       want.vbat_mv,     got.vbat_mv);
            compare_field("isense_ma",     want.isense_ma,   got.isense_ma);
            compare_field("charging",      want.charging,    got.charging);
            compare_field("event_res",     want.ev,          got.ev);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_opcode;
    logic                  i_charger_present;
    logic                  i_cv_detected;
    logic [ADC_BITS-1:0]   i_vbat_code;
    logic [ADC_BITS-1:0]   i_isense_code;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_charger_on;
    logic                  o_cc_mode;
    logic [LEVEL_W-1:0]    o_current_level;
    logic                  o_level_valid;
    logic [MV_W-1:0]       o_vbat_mv;
    logic [ISEN_W-1:0]     o_isense_ma;
    logic                  o_charging;
    logic [1:0]            o_event_res;

    charge_checker sb = new();
    int unsigned   n_settings;

    battery_charge_supervisor dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_charger_present (i_charger_present),
        .i_cv_detected     (i_cv_detected),
        .i_vbat_code       (i_vbat_code),
        .i_isense_code     (i_isense_code),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_charger_on      (o_charger_on),
        .o_cc_mode         (o_cc_mode),
        .o_current_level   (o_current_level),
        .o_level_valid     (o_level_valid),
        .o_vbat_mv         (o_vbat_mv),
        .o_isense_ma       (o_isense_ma),
        .o_charging        (o_charging),
        .o_event_res       (o_event_res)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop: even the slowest legal run is far shorter than this.
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Present one item after an optional gap and hold it until the block takes it.
    // Valid stays high on return, so a back-to-back item never drops it.
    task automatic drive_item(input t_sense_item it, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_opcode          <= it.op;
        i_charger_present <= it.present;
        i_cv_detected     <= it.cv;
        i_vbat_code       <= it.vbat;
        i_isense_code     <= it.isense;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_item(it);
    endtask

    task automatic tick_item(input t_opcode op, input logic present, input logic cv,
                             input int unsigned vbat, input int unsigned isense);
        t_sense_item it;
        it.op      = op;
        it.present = present;
        it.cv      = cv;
        it.vbat    = ADC_BITS'(vbat);
        it.isense  = ADC_BITS'(isense);
        drive_item(it, $urandom_range(0, 11));
    endtask

    // Drop valid and hold off until every predicted result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    // Drain, then allow the pipeline depth to pass before touching a register.
    task automatic settle_block();
        drain_results();
        repeat (5) @(posedge i_clk);
    endtask

    // Write all five registers back to back, then one unused index the block must ignore.
    task automatic load_settings(input logic [CFG_W-1:0] v_max, input logic [CFG_W-1:0] v_min,
                                 input logic [CFG_W-1:0] v_rech, input logic [CFG_W-1:0] v_start,
                                 input logic [CFG_W-1:0] v_wait);
        t_cfg_index           regs [5];
        logic [CFG_W-1:0]     vals [5];
        logic [CFG_IDX_W-1:0] spare;
        logic [CFG_W-1:0]     junk;

        regs  = '{CFG_MAX_CURRENT, CFG_MIN_CURRENT, CFG_RECHARGE_MV,
                  CFG_START_TICKS, CFG_WAIT_TICKS};
        vals  = '{v_max, v_min, v_rech, v_start, v_wait};
        spare = CFG_IDX_W'($urandom_range(CFG_WAIT_TICKS + 1, (1 << CFG_IDX_W) - 1));
        junk  = CFG_W'($urandom);
        for (int i = 0; i < 5; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            sb.write_reg(regs[i], vals[i]);
            @(posedge i_clk);
        end
        i_cfg_index <= spare;
        i_cfg_data  <= junk;
        sb.write_reg(spare, junk);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Build one item of the given kind of stretch. Charging stretches keep the sense
    // node well above the battery, tapering ones within a code or two, resting ones
    // at or below it; noise leaves every field to chance.
    function automatic t_sense_item make_item(t_segment seg, logic present);
        t_sense_item it;
        int unsigned base;
        int unsigned sense;

        base  = $urandom_range(0, CODE_FULL);
        sense = $urandom_range(0, CODE_FULL);
        it.op      = ($urandom_range(0, 40) == 0) ? OP_DETECT : OP_TICK;
        it.present = present;
        it.cv      = ($urandom_range(0, 5) == 0);
        case (seg)
            SEG_CHARGE: begin
                base  = $urandom_range(200, 900);
                sense = base + $urandom_range(3, 120);
            end
            SEG_TAPER:  sense = base + $urandom_range(0, 2);
            SEG_REST:   sense = base - ((base < 40) ? base : $urandom_range(0, 40));
            default: begin
                it.op      = ($urandom_range(0, 5) == 0) ? OP_DETECT : OP_TICK;
                it.present = 1'($urandom_range(0, 1));
                it.cv      = 1'($urandom_range(0, 1));
            end
        endcase
        it.vbat   = ADC_BITS'(base);
        it.isense = ADC_BITS'((sense > CODE_FULL) ? CODE_FULL : sense);
        return it;
    endfunction

    // Random stretches of plausible charger behaviour with random content, some noise,
    // calm bursts with no gaps, and one full drain at a random point.
    task automatic random_phase(input int n_items);
        t_segment seg;
        int       seg_left;
        int       pick;
        int       drain_at;
        logic     present;
        logic     calm;

        seg      = SEG_NOISE;
        seg_left = 0;
        present  = 1'b0;
        calm     = 1'b0;
        drain_at = $urandom_range(20, n_items - 20);
        for (int sent = 1; sent <= n_items; sent++) begin
            if (seg_left == 0) begin
                pick = $urandom_range(0, 9);
                seg  = (pick < 4) ? SEG_CHARGE :
                       (pick < 6) ? SEG_TAPER  :
                       (pick < 9) ? SEG_REST   : SEG_NOISE;
                seg_left = $urandom_range(3, 40);
                present  = ($urandom_range(0, 7) != 0);
                calm     = ($urandom_range(0, 3) == 0);
            end
            drive_item(make_item(seg, present), calm ? 0 : $urandom_range(0, 11));
            seg_left--;
            if (sent == drain_at) drain_results();
        end
    endtask

    // Walk the default settings through the interesting transitions by hand.
    task automatic directed_items();
        tick_item(OP_DETECT, 1'b0, 1'b0, 0, 0);          // interrupt straight after reset
        tick_item(OP_TICK,   1'b0, 1'b0, 0, 0);
        tick_item(OP_TICK,   1'b0, 1'b1, 1023, 1023);
        // Charger arrives with a large current: count up to the debounce and start.
        repeat (6) tick_item(OP_TICK, 1'b1, 1'b0, 512, 1023);
        tick_item(OP_TICK,   1'b1, 1'b1, 512, 1023);     // constant voltage drops CC mode
        tick_item(OP_DETECT, 1'b1, 1'b1, 1023, 0);       // interrupt clears the debounce
        repeat (6) tick_item(OP_TICK, 1'b1, 1'b0, 300, 700);
        tick_item(OP_TICK,   1'b1, 1'b0, 700, 701);      // taper to minimum: complete
        tick_item(OP_TICK,   1'b1, 1'b0, 600, 600);      // below recharge, no current: restart
        tick_item(OP_TICK,   1'b1, 1'b0, 600, 590);      // wait count runs down
        tick_item(OP_TICK,   1'b1, 1'b0, 800, 0);        // sense below battery, above recharge
        tick_item(OP_TICK,   1'b1, 1'b0, 0, 1023);       // largest current
        tick_item(OP_TICK,   1'b0, 1'b0, 1023, 1023);    // charger removed
        tick_item(OP_TICK,   1'b1, 1'b1, 1023, 0);
    endtask

    // Result side: take each result, then stall for a random number of cycles,
    // with calm stretches where it never stalls.
    initial begin : result_sink
        int             hold;
        int             calm_left;
        logic           calm;
        t_charge_result got;

        hold        = 0;
        calm_left   = 0;
        calm        = 1'b0;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                if (hold == 0) i_out_stall <= 1'b0;
            end else if (o_out_valid) begin
                got.charger_on  = o_charger_on;
                got.cc_mode     = o_cc_mode;
                got.level       = o_current_level;
                got.level_valid = o_level_valid;
                got.vbat_mv     = o_vbat_mv;
                got.isense_ma   = o_isense_ma;
                got.charging    = o_charging;
                got.ev          = t_event'(o_event_res);
                sb.check_result(got);
                if (calm_left == 0) begin
                    calm      = ($urandom_range(0, 3) == 0);
                    calm_left = $urandom_range(10, 60);
                end
                calm_left--;
                hold = calm ? 0 : $urandom_range(0, 11);
                if (hold > 0) i_out_stall <= 1'b1;
            end
        end
    end

    // Main sequence: reset, hand-picked items, then random phases over a range of
    // register settings including both extremes and masked over-wide writes.
    initial begin : stimulus
        int guard;
        int leftover;

        n_settings        = 0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= '0;
        i_cfg_data        <= '0;
        i_in_valid        <= 1'b0;
        i_opcode          <= OP_TICK;
        i_charger_present <= 1'b0;
        i_cv_detected     <= 1'b0;
        i_vbat_code       <= '0;
        i_isense_code     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();
        random_phase(PHASE_ITEMS);
        for (int p = 1; p < PHASES; p++) begin
            settle_block();
            case (p)
                // Everything at zero: no current level and an immediate debounce.
                1: load_settings(0, 0, 0, 0, 0);
                // All ones: each register keeps only its own width.
                2: load_settings('1, '1, '1, '1, '1);
                // Just below and just at the lowest table limit.
                3: load_settings(69, 10, 5600, 1, 5);
                4: load_settings(70, 100, 3000, 3, 0);
                5: load_settings(1600, 30, 4200, 15, 63);
                6: load_settings(CFG_W'($urandom_range(0, 2047)),
                                 CFG_W'($urandom_range(0, 150)),
                                 CFG_W'($urandom_range(2500, 5600)),
                                 CFG_W'($urandom_range(1, 15)),
                                 CFG_W'($urandom_range(0, 63)));
                default: load_settings(CFG_W'($urandom_range(0, 8191)),
                                       CFG_W'($urandom_range(0, 8191)),
                                       CFG_W'($urandom_range(0, 8191)),
                                       CFG_W'($urandom_range(0, 8191)),
                                       CFG_W'($urandom_range(0, 8191)));
            endcase
            random_phase(PHASE_ITEMS);
        end

        // Wind down: no more items, wait for the tail, then a few spare cycles.
        i_in_valid <= 1'b0;
        guard = 0;
        while (sb.pending_results.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (6) @(posedge i_clk);
        leftover = sb.pending_results.size();
        if (leftover != 0)
            $display("%0d predicted results never came out", leftover);

        $display("Covered %0d items (%0d detect interrupts) across %0d register settings.",
                 sb.n_items, sb.n_detect, n_settings + 1);
        $display("Events seen: %0d started, %0d complete, %0d restart; %0d results checked.",
                 sb.n_started, sb.n_complete, sb.n_restart, sb.n_checked);
        if (sb.mismatches == 0 && leftover == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
